// ----- design/wrh_pkg.sv -----
// Package for the wind-rose histogram core: transaction payload types,
// status, kind and register codes, and the fixed-point constants of the sector divider.
// Has no dependencies. wrh_classify, wrh_update and the core import it; wrh_ram does not.
`default_nettype none

package wrh_pkg;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_OTHER_STATION = 2'd1;
  localparam logic [1:0] ST_NEG_SPEED     = 2'd2;
  localparam logic [1:0] ST_DIR_RANGE     = 2'd3;

  // Register index (byte address bit 2)
  localparam logic REG_STATION_ID = 1'b0;

  // Widths of the fixed result fields
  localparam int OUT_CLASS_W  = 3;
  localparam int OUT_SECTOR_W = 4;
  localparam int OUT_COUNT_W  = 32;

  // Direction range, in tenths of a degree
  localparam logic [11:0] FULL_CIRCLE_TENTHS = 12'd3600;

  // floor(x / 3600) = (x * DIR_RECIP) >> DIR_SHIFT, exact for x < 2^18,
  // which covers direction * sectors for up to 64 sectors.
  localparam int unsigned DIR_RECIP = 298262;
  localparam int          DIR_SHIFT = 30;
  localparam int          PROD_W    = 37;

  // Input transaction
  typedef struct packed {
    logic               kind;
    logic [15:0]        station;
    logic signed [11:0] speed_tenths;
    logic [11:0]        direction_tenths;
    logic [6:0]         bin_index;
  } wrh_in_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]              status;
    logic [OUT_CLASS_W-1:0]  speed_class;
    logic [OUT_SECTOR_W-1:0] direction_sector;
    logic [OUT_COUNT_W-1:0]  bin_count;
  } wrh_out_t;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic [1:0] status;
    logic       count_en;   // valid sample: increment its bin
  } wrh_tag_t;

endpackage

`default_nettype wire

// ----- design/wrh_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// Read data holds while the read enable is low. Uses no package.
`default_nettype none

module wrh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/wrh_classify.sv -----
// Front-end classifier: status checks, speed class, direction sector and
// read-index decode for one input transaction. Depends on wrh_pkg.
`default_nettype none

module wrh_classify
  import wrh_pkg::*;
#(
  parameter int SPEED_CLASSES     = 6,
  parameter int DIRECTION_SECTORS = 16
) (
  input  wire wrh_in_t                                item,
  input  wire logic [15:0]                            station_id,
  output wrh_tag_t                                    tag,
  output logic [$clog2(SPEED_CLASSES)-1:0]            cls,
  output logic [$clog2(DIRECTION_SECTORS)-1:0]        sec
);

  localparam int CLS_W    = $clog2(SPEED_CLASSES);
  localparam int SEC_W    = $clog2(DIRECTION_SECTORS);
  localparam int BINS     = SPEED_CLASSES * DIRECTION_SECTORS;
  localparam int Q_W      = PROD_W - DIR_SHIFT;
  localparam int unsigned DIR_MULT = DIRECTION_SECTORS * DIR_RECIP;

  logic [11:0]       spd_u;
  logic [CLS_W-1:0]  spd_cls;
  logic [PROD_W-1:0] dir_prod;
  logic [Q_W-1:0]    dir_q;
  logic [SEC_W-1:0]  dir_sec;
  logic [10:0]       idx_ext;
  logic [CLS_W-1:0]  rd_cls;
  logic [10:0]       rd_rem;
  logic [1:0]        smp_status;

  // Speed class: first threshold (2k+1) m/s that the speed is below
  always_comb begin
    spd_u   = $unsigned(item.speed_tenths);
    spd_cls = CLS_W'(SPEED_CLASSES - 1);
    for (int k = SPEED_CLASSES - 2; k >= 0; k--) begin
      if (spd_u < 12'((2 * k + 1) * 10)) begin
        spd_cls = CLS_W'(k);
      end
    end
  end

  // Sector = floor(dir * sectors / 3600) by reciprocal multiply
  always_comb begin
    dir_prod = PROD_W'(item.direction_tenths) * PROD_W'(DIR_MULT);
    dir_q    = dir_prod[PROD_W-1:DIR_SHIFT];
    if (dir_q >= Q_W'(DIRECTION_SECTORS)) begin
      dir_sec = SEC_W'(DIRECTION_SECTORS - 1);
    end else begin
      dir_sec = dir_q[SEC_W-1:0];
    end
  end

  // Read decode: class and sector of the bin index
  always_comb begin
    idx_ext = 11'(item.bin_index);
    rd_cls  = '0;
    for (int k = 1; k < SPEED_CLASSES; k++) begin
      if (idx_ext >= 11'(k * DIRECTION_SECTORS)) begin
        rd_cls = CLS_W'(k);
      end
    end
    rd_rem = idx_ext - 11'(rd_cls) * 11'(DIRECTION_SECTORS);
  end

  // Sample checks in priority order
  always_comb begin
    priority if (item.station != station_id) begin
      smp_status = ST_OTHER_STATION;
    end else if (item.speed_tenths[11]) begin
      smp_status = ST_NEG_SPEED;
    end else if (item.direction_tenths >= FULL_CIRCLE_TENTHS) begin
      smp_status = ST_DIR_RANGE;
    end else begin
      smp_status = ST_OK;
    end
  end

  // Select by kind; rejected items carry zero class and sector
  always_comb begin
    tag.count_en = 1'b0;
    cls          = '0;
    sec          = '0;
    if (item.kind == KIND_READ) begin
      if (idx_ext < 11'(BINS)) begin
        tag.status = ST_OK;
        cls        = rd_cls;
        sec        = rd_rem[SEC_W-1:0];
      end else begin
        tag.status = ST_DIR_RANGE;
      end
    end else begin
      tag.status = smp_status;
      if (smp_status == ST_OK) begin
        tag.count_en = 1'b1;
        cls          = spd_cls;
        sec          = dir_sec;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/wrh_update.sv -----
// Read-modify-write unit: forwards the last write-back over stale RAM data,
// saturating increment, and write-back to the counter RAM. Depends on wrh_pkg.
`default_nettype none

module wrh_update
  import wrh_pkg::*;
#(
  parameter int COUNT_WIDTH = 32,
  parameter int ADDR_W      = 7
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   go,
  input  wire wrh_tag_t               tag,
  input  wire logic [ADDR_W-1:0]      addr,
  input  wire logic [COUNT_WIDTH-1:0] rdata,
  output logic [COUNT_WIDTH-1:0]      count,
  output logic                        we,
  output logic [ADDR_W-1:0]           waddr,
  output logic [COUNT_WIDTH-1:0]      wdata
);

  logic                   lw_valid_r;
  logic [ADDR_W-1:0]      lw_addr_r;
  logic [COUNT_WIDTH-1:0] lw_data_r;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] inc;

  // RAM read was issued on the edge of the last write: forward it on a hit
  always_comb begin
    if (lw_valid_r && (lw_addr_r == addr)) begin
      cur = lw_data_r;
    end else begin
      cur = rdata;
    end
    inc   = (&cur) ? cur : cur + COUNT_WIDTH'(1);
    count = tag.count_en ? inc : cur;
    we    = go && tag.count_en;
    waddr = addr;
    wdata = inc;
  end

  // Last write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (we) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      lw_addr_r <= addr;
      lw_data_r <= inc;
    end
  end

endmodule

`default_nettype wire

// ----- design/wind_rose_histogram_core.sv -----
// Wind-rose histogram core: classify stage, counter RAM read, read-modify-write
// and output register. Depends on wrh_pkg, wrh_classify, wrh_update, wrh_ram.
//
//  Channel | Ports                          | Direction | Transaction
//  --------+--------------------------------+-----------+-----------------------
//  in      | in_valid, in_stall, in_data    | input     | sample or bin read
//  out     | out_valid, out_stall, out_data | output    | one result per item
//  cfg     | cfg_psel .. cfg_pready         | input     | station_id register
//
// One item per cycle sustained while out_stall is low; after acceptance an
// item passes the RAM read, then the read-modify-write into the output
// register; classification is done in the accepting cycle.
// Back-to-back hits on one bin are served by forwarding the last write-back.
// After reset the counter RAM is cleared one entry a cycle, all SPEED_CLASSES *
// DIRECTION_SECTORS entries (96 by default), with in_stall held high.
// out_stall back-pressures stage by stage; empty stages still fill.
`default_nettype none

module wind_rose_histogram_core
  import wrh_pkg::*;
#(
  parameter int SPEED_CLASSES     = 6,
  parameter int DIRECTION_SECTORS = 16,
  parameter int COUNT_WIDTH       = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire wrh_in_t     in_data,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output wrh_out_t         out_data,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int   CLS_W  = $clog2(SPEED_CLASSES);
  localparam int   SEC_W  = $clog2(DIRECTION_SECTORS);
  localparam int   BINS   = SPEED_CLASSES * DIRECTION_SECTORS;
  localparam int   ADDR_W = $clog2(BINS);

  // Configuration
  logic [15:0] station_id_r;
  logic        cfg_wr;

  // Clearing pass
  logic              clr_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // Pipeline
  logic              s1_valid_r, s2_valid_r, out_valid_r;
  wrh_tag_t          cls_tag, s1_tag_r, s2_tag_r;
  logic [CLS_W-1:0]  cls_cls, s1_cls_r, s2_cls_r;
  logic [SEC_W-1:0]  cls_sec, s1_sec_r, s2_sec_r;
  logic [ADDR_W-1:0] s1_addr, s2_addr_r;
  wrh_out_t          out_data_r, out_nxt;
  logic              out_en, s2_en, s1_en, s2_go, s1_mv, in_acc;

  // Counter RAM and update
  logic [COUNT_WIDTH-1:0] ram_rdata, upd_count, upd_wdata, ram_wdata;
  logic [ADDR_W-1:0]      upd_waddr, ram_waddr;
  logic                   upd_we, ram_we;

  // APB register access
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_id_r <= '0;
    end else if (cfg_wr && (cfg_paddr[2] == REG_STATION_ID)) begin
      station_id_r <= cfg_pwdata[15:0];
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_STATION_ID) begin
      cfg_prdata = {16'd0, station_id_r};
    end else begin
      cfg_prdata = '0;
    end
  end

  // Clearing pass over the RAM after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(BINS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Stage flow control
  assign out_en   = !out_valid_r || !out_stall;
  assign s2_go    = s2_valid_r && out_en;
  assign s2_en    = !s2_valid_r || out_en;
  assign s1_mv    = s1_valid_r && s2_en;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_stall = clr_r || !s1_en;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= in_acc;
      end
      if (s2_en) begin
        s2_valid_r <= s1_mv;
      end
      if (out_en) begin
        out_valid_r <= s2_go;
      end
    end
  end

  // Stage 1: classify
  wrh_classify #(
    .SPEED_CLASSES     (SPEED_CLASSES),
    .DIRECTION_SECTORS (DIRECTION_SECTORS)
  ) u_classify (
    .item       (in_data),
    .station_id (station_id_r),
    .tag        (cls_tag),
    .cls        (cls_cls),
    .sec        (cls_sec)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_tag_r <= cls_tag;
      s1_cls_r <= cls_cls;
      s1_sec_r <= cls_sec;
    end
  end

  // Stage 2: bin address and RAM read
  assign s1_addr = ADDR_W'(s1_cls_r) * ADDR_W'(DIRECTION_SECTORS) + ADDR_W'(s1_sec_r);

  always_ff @(posedge clk) begin
    if (s1_mv) begin
      s2_tag_r  <= s1_tag_r;
      s2_cls_r  <= s1_cls_r;
      s2_sec_r  <= s1_sec_r;
      s2_addr_r <= s1_addr;
    end
  end

  // Stage 3: read-modify-write
  wrh_update #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_update (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (s2_go),
    .tag   (s2_tag_r),
    .addr  (s2_addr_r),
    .rdata (ram_rdata),
    .count (upd_count),
    .we    (upd_we),
    .waddr (upd_waddr),
    .wdata (upd_wdata)
  );

  // RAM write port shared with the clearing pass
  always_comb begin
    if (clr_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_we;
      ram_waddr = upd_waddr;
      ram_wdata = upd_wdata;
    end
  end

  wrh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BINS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s1_mv),
    .raddr (s1_addr),
    .rdata (ram_rdata)
  );

  // Output register; rejected items report zero fields
  always_comb begin
    out_nxt.status           = s2_tag_r.status;
    out_nxt.speed_class      = OUT_CLASS_W'(s2_cls_r);
    out_nxt.direction_sector = OUT_SECTOR_W'(s2_sec_r);
    if (s2_tag_r.status == ST_OK) begin
      out_nxt.bin_count = OUT_COUNT_W'(upd_count);
    end else begin
      out_nxt.bin_count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // No transaction may be in flight while the RAM is being cleared
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> (!s1_valid_r && !s2_valid_r))
    else $error("pipeline busy during clearing pass");

  // A counted sample never leaves a bin at zero (saturation, no wrap)
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_go && s2_tag_r.count_en) |-> (upd_wdata != '0))
    else $error("counter wrapped to zero");

  // Counter write-back only with a departing sample
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && !clr_r) |-> (s2_go && s2_tag_r.status == ST_OK))
    else $error("RAM written without a completing sample");
`endif

endmodule

`default_nettype wire
